>>> sv/bbe_pkg.sv
// Shared types, register codes and the rounding divider of the 3x3 box blur.
package bbe_pkg;

	// Configuration port
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 13;

	// Fixed field widths
	localparam int ROW_W = 12;
	localparam int COL_W = 11;
	localparam int CH_W  = 8;
	localparam int SUM_W = 12;

	// Reciprocals for the divide by 12 and by 18 (2n for n = 6 and 9)
	localparam logic [15:0] RECIP_6     = 16'd5462;
	localparam logic [15:0] RECIP_9     = 16'd3641;
	localparam int          RECIP_SHIFT = 16;

	typedef enum logic [CFG_IW-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	// Position of a pixel and the frame flags derived from it
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             row_ge1;
		logic             row_ge2;
		logic             col_ge1;
		logic             col_ge2;
		logic             last_row;
		logic             last_col;
	} pos_t;

	// Neighborhood size
	typedef enum logic [1:0] {
		CNT_4,
		CNT_6,
		CNT_9
	} cnt_t;

	// One result before the final divide
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		cnt_t             cnt;
		logic             last;
	} res_t;

	// (2*sum + n) / (2*n), rounded half up mean
	function automatic logic [CH_W-1:0] mean_div(logic [SUM_W-1:0] sum, cnt_t cnt);
		logic [SUM_W:0]   num;
		logic [28:0]      prod;
		logic [CH_W-1:0]  q;
		num  = '0;
		prod = '0;
		q    = '0;
		case (cnt)
			CNT_4: begin
				num = {sum, 1'b0} + 13'd4;
				q   = num[10:3];
			end
			CNT_6: begin
				num  = {sum, 1'b0} + 13'd6;
				prod = 29'(num) * 29'(RECIP_6);
				q    = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
			end
			CNT_9: begin
				num  = {sum, 1'b0} + 13'd9;
				prod = 29'(num) * 29'(RECIP_9);
				q    = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
			end
			default: q = '0;
		endcase
		return q;
	endfunction

endpackage

>>> sv/box_blur_3x3_edge_aware_core.sv
// Streaming 3x3 box blur of RGB pixels in raster order, edge aware.
// Takes one pixel per cycle while in_stall is low. Each pixel causes up to four results
// and the output port moves one result per cycle while out_stall is low, so a pixel in
// the last column or last row holds the input until its two results are sent and the
// last pixel of a frame until its four are; all other pixels give at most one result.
// The line memory is read when a pixel is accepted; each result is summed into stage 2
// and then divided into the output register. The two previous rows sit in one line
// memory of MAX_WIDTH entries that is read when a pixel is accepted and written back when
// it leaves the sum stage. Line memory entries start undefined and need no clearing pass.
// A configuration write restarts the frame at row 0, column 0; heights are clamped to
// 2..MAX_HEIGHT, and widths are taken from the low 12 bits of cfg_data and clamped to
// 2..MAX_WIDTH.
module box_blur_3x3_edge_aware_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bbe_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [bbe_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bbe_pkg::CH_W-1:0]     in_red,
	input  logic [bbe_pkg::CH_W-1:0]     in_green,
	input  logic [bbe_pkg::CH_W-1:0]     in_blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bbe_pkg::ROW_W-1:0]    out_row,
	output logic [bbe_pkg::COL_W-1:0]    out_col,
	output logic [bbe_pkg::CH_W-1:0]     out_red,
	output logic [bbe_pkg::CH_W-1:0]     out_green,
	output logic [bbe_pkg::CH_W-1:0]     out_blue,
	output logic                         last_of_run
);
	import bbe_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic          cfg_we;
	logic [31:0]   w_clamp;
	logic [31:0]   h_clamp;
	logic [CW-1:0] wm1_q;
	logic [RW-1:0] hm1_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	pos_t          pos_in;
	logic          s1_valid_q;
	pos_t          pos_s1;
	pix_t          cur_s1;
	logic [CW-1:0] col_s1;
	logic [47:0]   line_rd;
	pix_t          above_s1;
	pix_t          two_above_s1;
	logic          s1_adv;
	logic          s2_valid;
	res_t          res_s2;
	logic          mean_ready;

	// Configuration: always ready, values clamped when written
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready &&
		(cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		w_clamp = 32'(cfg_data[11:0]);
		if (w_clamp < 32'd2) w_clamp = 32'd2;
		if (w_clamp > 32'(MAX_WIDTH)) w_clamp = 32'(MAX_WIDTH);
		h_clamp = 32'(cfg_data);
		if (h_clamp < 32'd2) h_clamp = 32'd2;
		if (h_clamp > 32'(MAX_HEIGHT)) h_clamp = 32'(MAX_HEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= CW'((MAX_WIDTH < 2048 ? MAX_WIDTH : 2048) - 1);
			hm1_q <= RW'((MAX_HEIGHT < 4096 ? MAX_HEIGHT : 4096) - 1);
		end else if (cfg_valid && cfg_ready && cfg_index == REG_FRAME_WIDTH) begin
			wm1_q <= CW'(w_clamp - 32'd1);
		end else if (cfg_valid && cfg_ready && cfg_index == REG_FRAME_HEIGHT) begin
			hm1_q <= RW'(h_clamp - 32'd1);
		end
	end

	// Input transfer and raster position
	assign in_stall = s1_valid_q && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == wm1_q) begin
				col_q <= '0;
				row_q <= (row_q == hm1_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		pos_in.row      = ROW_W'(row_q);
		pos_in.col      = COL_W'(col_q);
		pos_in.row_ge1  = 32'(row_q) >= 32'd1;
		pos_in.row_ge2  = 32'(row_q) >= 32'd2;
		pos_in.col_ge1  = 32'(col_q) >= 32'd1;
		pos_in.col_ge2  = 32'(col_q) >= 32'd2;
		pos_in.last_row = row_q == hm1_q;
		pos_in.last_col = col_q == wm1_q;
	end

	// Stage 1: pixel waits for its line memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos_in;
			cur_s1 <= {in_red, in_green, in_blue};
			col_s1 <= col_q;
		end
	end

	// Line memory: {row r-2, row r-1} per column, written back as {row r-1, row r}
	bbe_ram #(
		.WIDTH (48),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata ({above_s1, cur_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	assign two_above_s1 = line_rd[47:24];
	assign above_s1     = line_rd[23:0];

	bbe_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid_q),
		.pos_s1       (pos_s1),
		.cur_s1       (cur_s1),
		.above_s1     (above_s1),
		.two_above_s1 (two_above_s1),
		.mean_ready   (mean_ready),
		.s1_adv       (s1_adv),
		.s2_valid     (s2_valid),
		.res_s2       (res_s2)
	);

	bbe_mean u_mean (
		.clk         (clk),
		.arst_n      (arst_n),
		.s2_valid    (s2_valid),
		.res_s2      (res_s2),
		.mean_ready  (mean_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.last_of_run (last_of_run)
	);

	// A new read never hits the column being written back in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s1_adv |-> col_q != col_s1)
		else $error("line memory read and write collide");

	// Raster position stays inside the configured frame
	assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wm1_q && row_q <= hm1_q)
		else $error("raster position outside frame");

	// Stage 1 only releases a pixel it holds
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> s1_valid_q)
		else $error("stage 1 released without a pixel");

	// A pixel accepted while stage 1 is empty or advancing is held there on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted pixel lost before stage 1");

endmodule

>>> sv/bbe_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module bbe_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/bbe_emit.sv
// Column window, result sequencer and neighborhood sums (stage 1 to stage 2).
module bbe_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s1_valid,
	input  bbe_pkg::pos_t pos_s1,
	input  bbe_pkg::pix_t cur_s1,
	input  bbe_pkg::pix_t above_s1,
	input  bbe_pkg::pix_t two_above_s1,
	input  logic          mean_ready,
	output logic          s1_adv,
	output logic          s2_valid,
	output bbe_pkg::res_t res_s2
);
	import bbe_pkg::*;

	pix_t       col0_q [3];
	pix_t       col1_q [3];
	pix_t       win [3][3];
	logic [1:0] seq_q;
	logic [1:0] seq_nxt;
	logic       seq_last;
	logic       has_res;
	logic       load_s2;
	logic       emit_now;
	logic [2:0] cm;
	logic [2:0] rm;
	res_t       res;
	logic       s2_valid_q;

	// Window grid: index 0 is column c-2, 1 is c-1, 2 is c; rows likewise
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			win[0][j] = col0_q[j];
			win[1][j] = col1_q[j];
		end
		win[2][0] = two_above_s1;
		win[2][1] = above_s1;
		win[2][2] = cur_s1;
	end

	// Result order: inner, right edge, bottom edge, corner
	function automatic logic allowed(logic [1:0] t, logic lc, logic lr);
		return (!t[0] || lc) && (!t[1] || lr);
	endfunction

	always_comb begin
		seq_nxt  = seq_q;
		seq_last = 1'b1;
		for (int k = 3; k >= 1; k--) begin
			if (seq_q < 2'(k) && allowed(2'(k), pos_s1.last_col, pos_s1.last_row)) begin
				seq_nxt  = 2'(k);
				seq_last = 1'b0;
			end
		end
	end

	assign has_res  = pos_s1.row_ge1 && pos_s1.col_ge1;
	assign load_s2  = !s2_valid_q || mean_ready;
	assign emit_now = s1_valid && has_res && load_s2;
	assign s1_adv   = s1_valid && (!has_res || (load_s2 && seq_last));

	// Sums over the in-frame members of the selected neighborhood
	always_comb begin
		cm = {2'b11, !seq_q[0] && pos_s1.col_ge2};
		rm = {2'b11, !seq_q[1] && pos_s1.row_ge2};
		res.row       = seq_q[1] ? pos_s1.row : pos_s1.row - 1'b1;
		res.col       = seq_q[0] ? pos_s1.col : pos_s1.col - 1'b1;
		res.sum_red   = '0;
		res.sum_green = '0;
		res.sum_blue  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (cm[i] && rm[j]) begin
					res.sum_red   = res.sum_red + SUM_W'(win[i][j].red);
					res.sum_green = res.sum_green + SUM_W'(win[i][j].green);
					res.sum_blue  = res.sum_blue + SUM_W'(win[i][j].blue);
				end
			end
		end
		if (cm[0] && rm[0]) begin
			res.cnt = CNT_9;
		end else if (cm[0] || rm[0]) begin
			res.cnt = CNT_6;
		end else begin
			res.cnt = CNT_4;
		end
		res.last = seq_last;
	end

	// Sequencer and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				seq_q <= seq_last ? 2'd0 : seq_nxt;
			end
			if (emit_now) begin
				s2_valid_q <= 1'b1;
			end else if (mean_ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (emit_now) begin
			res_s2 <= res;
		end
	end

	// Window shifts by one column when the pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				col0_q[j] <= '0;
				col1_q[j] <= '0;
			end
		end else if (s1_adv) begin
			for (int j = 0; j < 3; j++) begin
				col0_q[j] <= col1_q[j];
				col1_q[j] <= win[2][j];
			end
		end
	end

	assign s2_valid = s2_valid_q;

endmodule

>>> sv/bbe_mean.sv
// Final divide and output register with stall.
module bbe_mean (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s2_valid,
	input  bbe_pkg::res_t              res_s2,
	output logic                       mean_ready,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bbe_pkg::ROW_W-1:0]  out_row,
	output logic [bbe_pkg::COL_W-1:0]  out_col,
	output logic [bbe_pkg::CH_W-1:0]   out_red,
	output logic [bbe_pkg::CH_W-1:0]   out_green,
	output logic [bbe_pkg::CH_W-1:0]   out_blue,
	output logic                       last_of_run
);
	import bbe_pkg::*;

	logic out_valid_q;

	// Output register loads when empty or when its transfer completes
	assign mean_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mean_ready) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mean_ready && s2_valid) begin
			out_row     <= res_s2.row;
			out_col     <= res_s2.col;
			out_red     <= mean_div(res_s2.sum_red, res_s2.cnt);
			out_green   <= mean_div(res_s2.sum_green, res_s2.cnt);
			out_blue    <= mean_div(res_s2.sum_blue, res_s2.cnt);
			last_of_run <= res_s2.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule
